// File: hw/rtl/akl_pkg.sv
package akl_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int FILL_W  = $clog2(ENTRIES + 1);

    // Field widths.
    localparam int KEY_W      = 32;
    localparam int TIME_W     = 48;
    localparam int COUNT_W    = 8;
    localparam int INTERVAL_W = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_CONCURRENT = 1'b0,
        CFG_MIN_INTERVAL   = 1'b1
    } cfg_index_t;

    // Operation carried by an input beat.
    typedef enum logic [0:0] {
        FUNC_REQUEST = 1'b0,
        FUNC_FINISH  = 1'b1
    } func_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_GRANT    = 3'd1,
        ST_BUSY     = 3'd2,
        ST_SOON     = 3'd3,
        ST_FINISHED = 3'd4,
        ST_UNKNOWN  = 3'd5,
        ST_FULL     = 3'd6
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_HIT,
        S_ELAPSED,
        S_WINDOW,
        S_GRANT,
        S_PUSH
    } state_t;

    // Shared adder operations.
    typedef enum logic [0:0] {
        ALU_SUB = 1'b0,
        ALU_ADD = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [TIME_W-1:0] value;
        logic              borrow;
        logic              zero;
    } alu_res_t;

    // One table word.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  last_time;
    } entry_t;

    // Configuration handed to the sequencer.
    typedef struct packed {
        logic [COUNT_W-1:0]    max_concurrent;
        logic [INTERVAL_W-1:0] min_interval_ms;
    } cfg_t;

endpackage

// File: hw/rtl/akl_if.sv
interface akl_req_if;
    import akl_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [KEY_W-1:0]  site_key;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output func, output site_key, output now_ms, input ready);
    modport sink   (input valid, input func, input site_key, input now_ms, output ready);
endinterface

interface akl_resp_if;
    import akl_pkg::*;

    logic               valid;
    logic               ready;
    logic               granted;
    logic [2:0]         status;
    logic [COUNT_W-1:0] active_count;

    modport source (output valid, output granted, output status, output active_count,
                    input ready);
    modport sink   (input valid, input granted, input status, input active_count,
                    output ready);
endinterface

// File: hw/rtl/per_key_admission_limiter.sv
// Per-key admission limiter. Each request or finish beat is looked up in a
// table of ENTRIES keys by a linear scan, one table word per cycle from one
// memory read port, with a single shared adder doing the key compare, count
// check, elapsed-time subtract, interval compare and count update in turn.
// The scan length sets how long a lookup takes. A key found in the table
// goes from the scan to S_HIT and then to S_PUSH when it is a finish or is
// busy, on through S_ELAPSED and S_WINDOW when it comes too soon, and on
// through S_GRANT as well when it is granted. A key that is not in the table
// is scanned past every filled entry and goes through S_MISS to S_PUSH. The
// longest lookup is a grant at the last entry of a full table of 64. The
// sequencer goes back to idle on the edge that loads the result, so the next
// beat can be taken in the following cycle. The input is ready only while
// the sequencer is idle, but a finished result waiting in the output
// register does not hold off the next beat. Configuration writes take effect
// on the next cycle and are meant to be made while the block is idle.
module per_key_admission_limiter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [akl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [akl_pkg::CFG_DATA_W-1:0]    cfg_data,
    akl_req_if.sink                           req,
    akl_resp_if.source                        resp
);
    import akl_pkg::*;

    logic [COUNT_W-1:0]    max_concurrent_reg;
    logic [INTERVAL_W-1:0] min_interval_reg;
    cfg_t                  cfg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_concurrent_reg <= COUNT_W'(4);
            min_interval_reg   <= INTERVAL_W'(1000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAX_CONCURRENT: max_concurrent_reg <= cfg_data[COUNT_W-1:0];
                CFG_MIN_INTERVAL:   min_interval_reg   <= cfg_data[INTERVAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.max_concurrent  = max_concurrent_reg;
    assign cfg.min_interval_ms = min_interval_reg;

    akl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .resp  (resp)
    );

endmodule

// File: hw/rtl/akl_alu.sv
module akl_alu (
    input  akl_pkg::alu_op_t                op,
    input  logic [akl_pkg::TIME_W-1:0]      a,
    input  logic [akl_pkg::TIME_W-1:0]      b,
    output akl_pkg::alu_res_t               res
);
    import akl_pkg::*;

    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] b_eff;
    logic              carry_in;

    // One adder serves key compares, count checks, elapsed time, interval compares, increments and decrements.
    always_comb
    begin
        b_eff      = (op == ALU_ADD) ? b : ~b;
        carry_in   = (op == ALU_SUB);
        sum        = {1'b0, a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, carry_in};
        res.value  = sum[TIME_W-1:0];
        res.borrow = (op == ALU_SUB) && !sum[TIME_W];
        res.zero   = (sum[TIME_W-1:0] == '0);
    end

endmodule

// File: hw/rtl/akl_ctrl.sv
module akl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  akl_pkg::cfg_t cfg,
    akl_req_if.sink       req,
    akl_resp_if.source    resp
);
    import akl_pkg::*;

    // Sequencer and control registers.
    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers.
    func_t               func_reg, func_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [ADDR_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic                res_granted_reg, res_granted_next;
    status_t             res_status_reg, res_status_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;
    logic                out_granted_reg, out_granted_next;
    status_t             out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    // Table memory.
    entry_t              mem [ENTRIES];
    entry_t              rd_data_reg;
    logic                rd_en;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    entry_t              wr_data;

    // Shared unit.
    alu_op_t             alu_op;
    logic [TIME_W-1:0]   alu_a;
    logic [TIME_W-1:0]   alu_b;
    alu_res_t            alu_res;

    logic                scan_more;
    logic                match;
    logic                slot_free;
    logic [COUNT_W-1:0]  dec_count;

    akl_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign scan_more = (scan_idx_reg < fill_reg);
    assign match     = (state_reg == S_SCAN) && pend_reg && alu_res.zero;
    assign slot_free = !out_valid_reg || resp.ready;
    assign dec_count = alu_res.borrow ? '0 : alu_res.value[COUNT_W-1:0];

    assign req.ready         = (state_reg == S_IDLE);
    assign resp.valid        = out_valid_reg;
    assign resp.granted      = out_granted_reg;
    assign resp.status       = out_status_reg;
    assign resp.active_count = out_count_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    state_next = S_HIT;
                end
                else if (!pend_reg && !scan_more)
                begin
                    state_next = S_MISS;
                end
            end
            S_MISS:
            begin
                state_next = S_PUSH;
            end
            S_HIT:
            begin
                if (func_reg == FUNC_FINISH || !alu_res.borrow)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_ELAPSED;
                end
            end
            S_ELAPSED:
            begin
                state_next = S_WINDOW;
            end
            S_WINDOW:
            begin
                state_next = alu_res.borrow ? S_PUSH : S_GRANT;
            end
            S_GRANT:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath controls and register updates.
    always_comb
    begin
        func_next        = func_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        fill_next        = fill_reg;
        scan_idx_next    = scan_idx_reg;
        elapsed_next     = elapsed_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        res_count_next   = res_count_reg;
        alu_op           = ALU_SUB;
        alu_a            = '0;
        alu_b            = '0;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = pend_idx_reg;
        wr_data          = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                func_next     = func_t'(req.func);
                key_next      = req.site_key;
                now_next      = req.now_ms;
                scan_idx_next = '0;
            end
            S_SCAN:
            begin
                // Compare the word read last cycle while the next read goes out.
                alu_a = {{(TIME_W-KEY_W){1'b0}}, key_reg};
                alu_b = {{(TIME_W-KEY_W){1'b0}}, rd_data_reg.key};
                rd_en = scan_more && !match;
                if (rd_en)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_MISS:
            begin
                res_granted_next = 1'b0;
                res_count_next   = '0;
                if (func_reg == FUNC_FINISH)
                begin
                    res_status_next = ST_UNKNOWN;
                end
                else if (fill_reg == FILL_W'(ENTRIES))
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    wr_en             = 1'b1;
                    wr_addr           = fill_reg[ADDR_W-1:0];
                    wr_data.key       = key_reg;
                    wr_data.count     = COUNT_W'(1);
                    wr_data.last_time = now_reg;
                    fill_next         = fill_reg + 1'b1;
                    res_granted_next  = 1'b1;
                    res_status_next   = ST_NEW;
                    res_count_next    = COUNT_W'(1);
                end
            end
            S_HIT:
            begin
                alu_a = {{(TIME_W-COUNT_W){1'b0}}, rd_data_reg.count};
                if (func_reg == FUNC_FINISH)
                begin
                    // Decrement, holding at zero.
                    alu_b            = TIME_W'(1);
                    wr_en            = 1'b1;
                    wr_data.count    = dec_count;
                    res_granted_next = 1'b0;
                    res_status_next  = ST_FINISHED;
                    res_count_next   = dec_count;
                end
                else
                begin
                    alu_b = {{(TIME_W-COUNT_W){1'b0}}, cfg.max_concurrent};
                    if (!alu_res.borrow)
                    begin
                        res_granted_next = 1'b0;
                        res_status_next  = ST_BUSY;
                        res_count_next   = rd_data_reg.count;
                    end
                end
            end
            S_ELAPSED:
            begin
                alu_a        = now_reg;
                alu_b        = rd_data_reg.last_time;
                elapsed_next = alu_res.value;
            end
            S_WINDOW:
            begin
                alu_a = elapsed_reg;
                alu_b = {{(TIME_W-INTERVAL_W){1'b0}}, cfg.min_interval_ms};
                if (alu_res.borrow)
                begin
                    res_granted_next = 1'b0;
                    res_status_next  = ST_SOON;
                    res_count_next   = rd_data_reg.count;
                end
            end
            S_GRANT:
            begin
                alu_op            = ALU_ADD;
                alu_a             = {{(TIME_W-COUNT_W){1'b0}}, rd_data_reg.count};
                alu_b             = TIME_W'(1);
                wr_en             = 1'b1;
                wr_data.count     = alu_res.value[COUNT_W-1:0];
                wr_data.last_time = now_reg;
                res_granted_next  = 1'b1;
                res_status_next   = ST_GRANT;
                res_count_next    = alu_res.value[COUNT_W-1:0];
            end
            S_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Read tracking: the word in rd_data_reg belongs to pend_idx_reg.
    assign pend_next     = rd_en;
    assign pend_idx_next = rd_en ? scan_idx_reg[ADDR_W-1:0] : pend_idx_reg;

    // Output register loads once the previous beat has left.
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        if (state_reg == S_PUSH && slot_free)
        begin
            out_valid_next   = 1'b1;
            out_granted_next = res_granted_reg;
            out_status_next  = res_status_reg;
            out_count_next   = res_count_reg;
        end
        else if (resp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        key_reg         <= key_next;
        now_reg         <= now_next;
        pend_idx_reg    <= pend_idx_next;
        elapsed_reg     <= elapsed_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        res_count_reg   <= res_count_next;
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
    end

    // Table memory with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[scan_idx_reg[ADDR_W-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(ENTRIES))
        else $error("fill level beyond table size");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill level moved by more than one");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_MISS || state_reg == S_HIT || state_reg == S_GRANT))
        else $error("table write outside an update state");

    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_granted_reg) |->
            (out_status_reg == ST_NEW || out_status_reg == ST_GRANT))
        else $error("grant with a refusal status");

    a_push_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && state_next == S_IDLE) |=> out_valid_reg)
        else $error("result not loaded on leaving push");
`endif

endmodule
